/* sv/sliding_window_quote_stats_core_macros.svh */
// Assertion macros for the sliding window quote statistics core.
// Included by the core top level, the one module that carries concurrent checks; no other dependencies.
`ifndef SLIDING_WINDOW_QUOTE_STATS_CORE_MACROS_SVH
`define SLIDING_WINDOW_QUOTE_STATS_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWQS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swqs check failed");

// Next-cycle implication, disabled during reset.
`define SWQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swqs check failed");

`endif

/* sv/swqs_pkg.sv */
// Shared constants and types of the sliding window quote statistics core.
// No dependencies; used by every module and interface of the block.
package swqs_pkg;

   localparam int WINDOW_DAYS = 32;
   localparam int QUOTE_W     = 32;
   localparam int PTR_W       = (WINDOW_DAYS > 1) ? $clog2(WINDOW_DAYS) : 1;
   localparam int STEP_W      = $clog2(WINDOW_DAYS + 1);
   localparam int CNT_W       = $clog2(WINDOW_DAYS + 1);
   localparam int SUM_W       = QUOTE_W - 1 + CNT_W;
   localparam int DIV_STEP_W  = $clog2(SUM_W + 1);

   localparam int FIX_ONE = 65536;
   localparam logic signed [QUOTE_W-1:0] MARK_UNFILLED  = QUOTE_W'(-3 * FIX_ONE);
   localparam logic signed [QUOTE_W-1:0] LIMIT_UNFILLED = QUOTE_W'(-2 * FIX_ONE);
   localparam logic signed [QUOTE_W-1:0] ANSWER_NONE    = QUOTE_W'(-1 * FIX_ONE);

   typedef struct packed {
      logic                      en;
      logic [PTR_W-1:0]          addr;
      logic signed [QUOTE_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
   } rd_type;

endpackage

/* sv/swqs_req_if.sv */
// Request channel of the sliding window quote statistics core.
// Depends on swqs_pkg for the quote width.
interface swqs_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [swqs_pkg::QUOTE_W-1:0] quote;

   modport source (output valid, output quote, input ready);
   modport sink (input valid, input quote, output ready);
endinterface

/* sv/swqs_rsp_if.sv */
// Result channel of the sliding window quote statistics core.
// Depends on swqs_pkg for the quote width.
interface swqs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                waiting;
   logic signed [swqs_pkg::QUOTE_W-1:0] max_quote;
   logic signed [swqs_pkg::QUOTE_W-1:0] min_quote;
   logic signed [swqs_pkg::QUOTE_W-1:0] avg_quote;

   modport source (output valid, output waiting, output max_quote, output min_quote,
                   output avg_quote, input ready);
   modport sink (input valid, input waiting, input max_quote, input min_quote,
                 input avg_quote, output ready);
endinterface

/* sv/sliding_window_quote_stats_core.sv */
// Sliding window quote statistics core: top level with the scan sequencer.
// Uses swqs_pkg, swqs_req_if, swqs_rsp_if, swqs_window and swqs_divider.
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    quote (signed Q15.16)
//   rsp_chan   out   valid/ready    waiting, max_quote, min_quote, avg_quote
//
// Each request runs from accept to accept through one write, a scan of WINDOW_DAYS
// reads through the single store read port, and a restoring divide of one quotient bit
// per cycle for the mean. With the window unfilled or no non-negative quote in it the
// divide is skipped; a new request is taken only once the last one is through.
// Reset is synchronous; every entry then reads as the unfilled marker at once.
// A result waits in the output register while the next request is taken.
`include "sliding_window_quote_stats_core_macros.svh"

module sliding_window_quote_stats_core (
   input logic        clock,
   input logic        reset,
   swqs_req_if.sink   req_chan,
   swqs_rsp_if.source rsp_chan
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_EVAL = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [swqs_pkg::PTR_W-1:0]          ptr_ff, ptr_in;
   logic [swqs_pkg::PTR_W-1:0]          rd_addr_ff, rd_addr_in;
   logic [swqs_pkg::STEP_W-1:0]         step_ff, step_in;
   logic signed [swqs_pkg::QUOTE_W-1:0] oldest_ff, oldest_in;
   logic signed [swqs_pkg::QUOTE_W-1:0] mx_ff, mx_in;
   logic signed [swqs_pkg::QUOTE_W-1:0] mn_ff, mn_in;
   logic [swqs_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic [swqs_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                waiting_ff, waiting_in;
   logic signed [swqs_pkg::QUOTE_W-1:0] max_out_ff, max_out_in;
   logic signed [swqs_pkg::QUOTE_W-1:0] min_out_ff, min_out_in;
   logic signed [swqs_pkg::QUOTE_W-1:0] avg_out_ff, avg_out_in;

   swqs_pkg::wr_type                    wr;
   swqs_pkg::rd_type                    rd;
   logic signed [swqs_pkg::QUOTE_W-1:0] rd_data;
   logic                                div_start;
   logic                                div_done;
   logic [swqs_pkg::SUM_W-1:0]          div_quotient;
   logic                                accept_req;
   logic                                nonneg;

   swqs_window u_window (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   swqs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept_req     = req_chan.valid && req_chan.ready;
   assign nonneg         = !rd_data[swqs_pkg::QUOTE_W-1];

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      rd_addr_in   = rd_addr_ff;
      step_in      = step_ff;
      oldest_in    = oldest_ff;
      mx_in        = mx_ff;
      mn_in        = mn_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      waiting_in   = waiting_ff;
      max_out_in   = max_out_ff;
      min_out_in   = min_out_ff;
      avg_out_in   = avg_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      wr           = '0;
      rd           = '0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_req) begin
               wr.en      = 1'b1;
               wr.addr    = ptr_ff;
               wr.data    = req_chan.quote;
               ptr_in     = (ptr_ff == swqs_pkg::PTR_W'(swqs_pkg::WINDOW_DAYS - 1))
                            ? '0 : ptr_ff + 1'b1;
               rd_addr_in = ptr_in;
               step_in    = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_ff < swqs_pkg::STEP_W'(swqs_pkg::WINDOW_DAYS)) begin
               rd.en      = 1'b1;
               rd.addr    = rd_addr_ff;
               rd_addr_in = (rd_addr_ff == swqs_pkg::PTR_W'(swqs_pkg::WINDOW_DAYS - 1))
                            ? '0 : rd_addr_ff + 1'b1;
            end else begin
               state_in = ST_EVAL;
            end
            if (step_ff == swqs_pkg::STEP_W'(1)) begin
               oldest_in = rd_data;
               mx_in     = rd_data;
               mn_in     = rd_data;
               sum_in    = nonneg ? swqs_pkg::SUM_W'(rd_data[swqs_pkg::QUOTE_W-2:0]) : '0;
               cnt_in    = swqs_pkg::CNT_W'(nonneg);
            end else if (step_ff != '0) begin
               if (rd_data > mx_ff) begin
                  mx_in = rd_data;
               end
               if (nonneg) begin
                  if (mn_ff[swqs_pkg::QUOTE_W-1] || (rd_data < mn_ff)) begin
                     mn_in = rd_data;
                  end
                  sum_in = sum_ff + swqs_pkg::SUM_W'(rd_data[swqs_pkg::QUOTE_W-2:0]);
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            step_in = step_ff + 1'b1;
         end
         ST_EVAL: begin
            if ((oldest_ff < swqs_pkg::LIMIT_UNFILLED) || (cnt_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               waiting_in   = oldest_ff[swqs_pkg::QUOTE_W-1];
               if (oldest_ff < swqs_pkg::LIMIT_UNFILLED) begin
                  max_out_in = swqs_pkg::ANSWER_NONE;
                  min_out_in = swqs_pkg::ANSWER_NONE;
                  avg_out_in = swqs_pkg::ANSWER_NONE;
               end else begin
                  max_out_in = mx_ff;
                  min_out_in = mn_ff;
                  avg_out_in = (cnt_ff == '0) ? swqs_pkg::ANSWER_NONE
                               : div_quotient[swqs_pkg::QUOTE_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff <= rd_addr_in;
      step_ff    <= step_in;
      oldest_ff  <= oldest_in;
      mx_ff      <= mx_in;
      mn_ff      <= mn_in;
      sum_ff     <= sum_in;
      cnt_ff     <= cnt_in;
      waiting_ff <= waiting_in;
      max_out_ff <= max_out_in;
      min_out_ff <= min_out_in;
      avg_out_ff <= avg_out_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.waiting   = waiting_ff;
   assign rsp_chan.max_quote = max_out_ff;
   assign rsp_chan.min_quote = min_out_ff;
   assign rsp_chan.avg_quote = avg_out_ff;

   `SWQS_ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept_req, (state_ff == ST_SCAN) && (step_ff == '0))
   `SWQS_ASSERT_SAME(a_div_has_count, clock, reset, state_ff == ST_DIV, cnt_ff != '0)
   `SWQS_ASSERT_SAME(a_max_covers_min, clock, reset, state_ff == ST_DIV, mx_ff >= mn_ff)
   `SWQS_ASSERT_SAME(a_done_in_div, clock, reset, div_done, state_ff == ST_DIV)

endmodule

/* sv/swqs_window.sv */
// Window store: one write port, one registered read port, per-entry valid bits.
// Entries never written read as the unfilled marker. Depends on swqs_pkg.
module swqs_window (
   input  logic                                clock,
   input  logic                                reset,
   input  swqs_pkg::wr_type                    wr,
   input  swqs_pkg::rd_type                    rd,
   output logic signed [swqs_pkg::QUOTE_W-1:0] rd_data
);

   logic signed [swqs_pkg::QUOTE_W-1:0] mem_ff [swqs_pkg::WINDOW_DAYS];
   logic [swqs_pkg::WINDOW_DAYS-1:0]    valid_ff;
   logic signed [swqs_pkg::QUOTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= valid_ff[rd.addr] ? mem_ff[rd.addr] : swqs_pkg::MARK_UNFILLED;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/swqs_divider.sv */
// Restoring divider, one quotient bit per cycle, for the window mean.
// Divides the non-negative sum by the count of non-negative entries. Depends on swqs_pkg.
module swqs_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [swqs_pkg::SUM_W-1:0]       dividend,
   input  logic [swqs_pkg::CNT_W-1:0]       divisor,
   output logic                             done,
   output logic [swqs_pkg::SUM_W-1:0]       quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [swqs_pkg::DIV_STEP_W-1:0]  count_ff, count_in;
   logic [swqs_pkg::SUM_W-1:0]       quo_ff, quo_in;
   logic [swqs_pkg::CNT_W-1:0]       rem_ff, rem_in;
   logic [swqs_pkg::CNT_W-1:0]       div_ff, div_in;
   logic [swqs_pkg::CNT_W:0]         cand;
   logic                             fits;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cand     = {rem_ff, quo_ff[swqs_pkg::SUM_W-1]};
      fits     = (cand >= {1'b0, div_ff});
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? swqs_pkg::CNT_W'(cand - {1'b0, div_ff})
                         : cand[swqs_pkg::CNT_W-1:0];
         quo_in   = {quo_ff[swqs_pkg::SUM_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == swqs_pkg::DIV_STEP_W'(swqs_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
